// ----- sv/ctsl_pkg.sv -----
`timescale 1ns / 1ps
package ctsl_pkg;
  localparam int POS_BITS = 21;
  localparam logic signed [POS_BITS-1:0] POS_MAX = 21'sd1048575;
  localparam logic signed [POS_BITS-1:0] POS_MIN = -21'sd1048576;

  localparam logic [31:0] K1 = 32'd1686629713;
  localparam logic [31:0] K3 = 32'd693598668;
  localparam logic [31:0] K5 = 32'd85569306;
  localparam logic [31:0] K7 = 32'd5026995;
  localparam logic [31:0] K9 = 32'd172272;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  localparam logic [2:0] REG_CX = 3'd0;
  localparam logic [2:0] REG_CY = 3'd1;
  localparam logic [2:0] REG_CZ = 3'd2;
  localparam logic [2:0] REG_RAD = 3'd3;
  localparam logic [2:0] REG_INC = 3'd4;
  localparam logic [2:0] REG_MAXS = 3'd5;

  function automatic logic signed [POS_BITS-1:0] sat_pos(input logic signed [23:0] v);
    if (v > 24'(POS_MAX)) begin
      return POS_MAX;
    end else if (v < 24'(POS_MIN)) begin
      return POS_MIN;
    end
    return v[POS_BITS-1:0];
  endfunction
endpackage

// ----- sv/circle_trajectory_step_limiter.sv -----
`timescale 1ns / 1ps
// Circle trajectory step limiter. Each transfer on the in_ channel is one measured
// position; one goal comes back on out_. A sequencer drives one shared 32x32
// multiplier through the sine polynomial (two passes, cosine then sine), the radius
// scaling, the squared error and the divider numerator, then a bit-serial root
// (with start and done strobes) and a restoring divider per axis when the step is
// limited. After a transfer in_ready stays low until the goal is loaded into the
// output register, and longer while an earlier result there has not been taken.
// The output register lets the next item enter while a result waits.
module circle_trajectory_step_limiter
  import ctsl_pkg::*;
#(
  parameter int PHASE_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [POS_BITS-1:0] in_current_x,
  input  logic signed [POS_BITS-1:0] in_current_y,
  input  logic signed [POS_BITS-1:0] in_current_z,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [POS_BITS-1:0] out_goal_x,
  output logic signed [POS_BITS-1:0] out_goal_y,
  output logic signed [POS_BITS-1:0] out_goal_z,
  output logic                       out_step_limited,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [2:0]                 cfg_index,
  input  logic [31:0]                cfg_data
);
  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_TRIG = 8'b0000_0010,
    ST_RAD  = 8'b0000_0100,
    ST_ERR  = 8'b0000_1000,
    ST_ROOT = 8'b0001_0000,
    ST_DIV  = 8'b0010_0000,
    ST_OUT  = 8'b0100_0000,
    ST_WAIT = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic [3:0] step_r, step_nxt;
  logic       pass_r, pass_nxt;
  logic [1:0] ax_r, ax_nxt;

  logic signed [POS_BITS-1:0] cx_r, cy_r, cz_r;
  logic [15:0] rad_r, maxs_r;
  logic [PHASE_BITS-1:0] inc_r, phase_r;

  logic signed [POS_BITS-1:0] cur_r [3];
  logic signed [POS_BITS-1:0] goal_r [3];
  logic [31:0] t_r, s_r, p_r;
  logic [30:0] sv_r [2];
  logic [1:0]  quad_r;
  logic signed [22:0] e_r [3];
  logic [63:0] d2_r;
  logic [31:0] lim_r;
  logic        limited_r;

  logic signed [POS_BITS-1:0] og_r [3];
  logic ol_r, ovalid_r;

  // shared multiplier
  logic [31:0] ma, mb;
  logic [63:0] mp;
  assign mp = ma * mb;

  logic [31:0] t0;
  assign t0 = 32'(phase_r[PHASE_BITS-3:0]) << (32 - PHASE_BITS);

  logic [31:0] pm;
  assign pm = 32'(mp >> 30);

  logic [30:0] mag;
  logic neg;
  logic signed [23:0] ssum;
  logic [22:0] ae;
  logic [63:0] num;
  logic [31:0] p_r_nxt_k;

  logic sq_start, sq_done, dv_start, dv_done;
  logic [31:0] sq_root;
  logic [63:0] dv_q;

  ctsl_isqrt u_sqrt (.clk, .rst_n, .start(sq_start), .radicand(d2_r << 16),
                     .done(sq_done), .root(sq_root));
  ctsl_divider u_div (.clk, .rst_n, .start(dv_start), .dividend(num + 64'(lim_r >> 1)),
                      .divisor(lim_r), .done(dv_done), .quotient(dv_q));

  always_comb begin
    ae = e_r[ax_r][22] ? 23'(-e_r[ax_r]) : 23'(e_r[ax_r]);
    num = mp << 8;
  end

  // trig select: quadrant swaps and signs
  always_comb begin
    logic sw;
    sw = quad_r[0];
    if (ax_r == 2'd0) begin
      mag = sw ? sv_r[1] : sv_r[0];
      neg = (quad_r == 2'd1) || (quad_r == 2'd2);
    end else begin
      mag = sw ? sv_r[0] : sv_r[1];
      neg = quad_r[1];
    end
  end

  always_comb begin
    ma = '0;
    mb = '0;
    case (state_r)
      ST_TRIG: begin
        case (step_r)
          4'd0: begin ma = t_r; mb = t_r; end
          4'd1, 4'd2, 4'd3, 4'd4: begin ma = s_r; mb = p_r; end
          default: begin ma = t_r; mb = p_r; end
        endcase
      end
      ST_RAD: begin ma = 32'(rad_r); mb = 32'(mag); end
      ST_ERR: begin ma = 32'(ae); mb = 32'(ae); end
      ST_DIV: begin ma = 32'(ae); mb = 32'(maxs_r); end
      default: begin ma = 32'(maxs_r); mb = 32'(maxs_r); end
    endcase
  end

  always_comb begin
    logic [31:0] kk;
    logic [63:0] rv;
    logic signed [22:0] ev;
    state_nxt = state_r;
    step_nxt = step_r;
    pass_nxt = pass_r;
    ax_nxt = ax_r;
    sq_start = 1'b0;
    dv_start = 1'b0;
    kk = K1;
    rv = '0;
    ev = '0;
    ssum = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_TRIG;
          step_nxt = '0;
          pass_nxt = 1'b0;
        end
      end
      ST_TRIG: begin
        step_nxt = step_r + 4'd1;
        if (step_r == 4'd5) begin
          step_nxt = '0;
          if (pass_r) begin
            state_nxt = ST_RAD;
            ax_nxt = 2'd0;
          end
          pass_nxt = ~pass_r;
        end
        case (step_r)
          4'd1: kk = K7;
          4'd2: kk = K5;
          4'd3: kk = K3;
          default: kk = K1;
        endcase
      end
      ST_RAD: begin
        rv = (mp + 64'h2000_0000) >> 30;
        ev = neg ? 23'(-$signed({1'b0, rv[21:0]})) : $signed({1'b0, rv[21:0]});
        ssum = 24'(ax_r == 2'd0 ? cx_r : cz_r) + 24'(ev);
        if (ax_r == 2'd0) begin
          ax_nxt = 2'd2;
        end else begin
          state_nxt = ST_ERR;
          ax_nxt = 2'd0;
        end
      end
      ST_ERR: begin
        if (ax_r == 2'd2) begin
          state_nxt = ST_ROOT;
          ax_nxt = 2'd0;
        end else begin
          ax_nxt = ax_r + 2'd1;
        end
      end
      ST_ROOT: begin
        if (step_r == 4'd0) begin
          if (d2_r > mp) begin
            sq_start = 1'b1;
            step_nxt = 4'd1;
          end else begin
            state_nxt = ST_OUT;
          end
        end else if (sq_done) begin
          state_nxt = ST_DIV;
          step_nxt = '0;
          ax_nxt = 2'd0;
        end
      end
      ST_DIV: begin
        if (step_r == 4'd0) begin
          dv_start = 1'b1;
          step_nxt = 4'd1;
        end else if (dv_done) begin
          step_nxt = '0;
          if (ax_r == 2'd2) begin
            state_nxt = ST_OUT;
          end else begin
            ax_nxt = ax_r + 2'd1;
          end
        end
      end
      ST_OUT: begin
        if (!ovalid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    p_r_nxt_k = kk;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r <= '0;
      pass_r <= 1'b0;
      ax_r <= '0;
      phase_r <= '0;
      ovalid_r <= 1'b0;
      cx_r <= 21'sd9830;
      cy_r <= -21'sd26214;
      cz_r <= 21'sd44564;
      rad_r <= 16'd3277;
      inc_r <= PHASE_BITS'(1043);
      maxs_r <= 16'd328;
    end else begin
      state_r <= state_nxt;
      step_r <= step_nxt;
      pass_r <= pass_nxt;
      ax_r <= ax_nxt;
      if (state_r == ST_OUT && (!ovalid_r || out_ready)) begin
        ovalid_r <= 1'b1;
      end else if (out_valid && out_ready) begin
        ovalid_r <= 1'b0;
      end
      if (state_r == ST_RAD && ax_r == 2'd2) begin
        phase_r <= phase_r + inc_r;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CX: cx_r <= cfg_data[POS_BITS-1:0];
          REG_CY: cy_r <= cfg_data[POS_BITS-1:0];
          REG_CZ: cz_r <= cfg_data[POS_BITS-1:0];
          REG_RAD: rad_r <= cfg_data[15:0];
          REG_INC: inc_r <= PHASE_BITS'(cfg_data[15:0]);
          REG_MAXS: maxs_r <= cfg_data[15:0];
          default: ;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cur_r[0] <= in_current_x;
          cur_r[1] <= in_current_y;
          cur_r[2] <= in_current_z;
          quad_r <= phase_r[PHASE_BITS-1 -: 2];
          t_r <= 32'(ONE_Q30) - t0;
          p_r <= K9;
          limited_r <= 1'b0;
          d2_r <= '0;
        end
      end
      ST_TRIG: begin
        case (step_r)
          4'd0: begin s_r <= pm; end
          4'd1, 4'd2, 4'd3, 4'd4: p_r <= p_r_nxt_k - pm;
          default: begin
            sv_r[pass_r] <= (pm > 32'(ONE_Q30)) ? ONE_Q30 : pm[30:0];
            t_r <= t0;
            p_r <= K9;
          end
        endcase
      end
      ST_RAD: begin
        goal_r[ax_r] <= sat_pos(ssum);
        goal_r[1] <= cy_r;
      end
      ST_ERR: begin
        d2_r <= d2_r + 64'(mp[45:0]);
      end
      ST_ROOT: begin
        if (sq_done) begin
          lim_r <= sq_root;
        end
        if (step_r == 4'd0 && d2_r > mp) begin
          limited_r <= 1'b1;
        end
      end
      ST_DIV: begin
        if (dv_done) begin
          goal_r[ax_r] <= sat_pos(24'(cur_r[ax_r]) + (e_r[ax_r][22] ?
                          -24'(dv_q[22:0]) : 24'(dv_q[22:0])));
        end
      end
      ST_OUT: begin
        if (!ovalid_r || out_ready) begin
          og_r <= goal_r;
          ol_r <= limited_r;
        end
      end
      default: ;
    endcase
    if (state_r == ST_RAD && ax_r == 2'd2) begin
      for (int i = 0; i < 3; i++) begin
        e_r[i] <= 23'(i == 0 ? goal_r[0] : (i == 1 ? cy_r : sat_pos(ssum)))
                  - 23'(cur_r[i]);
      end
    end
  end

  assign in_ready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = ovalid_r;
  assign out_goal_x = og_r[0];
  assign out_goal_y = og_r[1];
  assign out_goal_z = og_r[2];
  assign out_step_limited = ol_r;

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == ST_TRIG) else $error("no start");
  a_lim_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> limited_r) else $error("div without limit");
  a_phase: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE && $past(state_r) == ST_IDLE |-> $stable(phase_r))
    else $error("phase moved");
`endif
endmodule

// ----- sv/ctsl_isqrt.sv -----
`timescale 1ns / 1ps
// Bit-serial integer square root, one result bit per cycle.
module ctsl_isqrt
  import ctsl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);
  logic [63:0] rem_r, rem_nxt;
  logic [63:0] root_r, root_nxt;
  logic [63:0] bit_r, bit_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [63:0] trial;

  assign trial = root_r + bit_r;

  always_comb begin
    rem_nxt = rem_r;
    root_nxt = root_r;
    bit_nxt = bit_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = radicand;
      root_nxt = '0;
      bit_nxt = 64'h4000_0000_0000_0000;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_r >= trial) begin
        rem_nxt = rem_r - trial;
        root_nxt = (root_r >> 1) + bit_r;
      end else begin
        root_nxt = root_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      if (bit_r[0]) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    root_r <= root_nxt;
    bit_r <= bit_nxt;
  end

  assign done = done_r;
  assign root = root_r[31:0];
endmodule

// ----- sv/ctsl_divider.sv -----
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module ctsl_divider
  import ctsl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);
  logic [63:0] q_r, q_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] sh;

  assign sh = {rem_r[31:0], q_r[63]};

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (sh >= {1'b0, divisor}) begin
        rem_nxt = sh - {1'b0, divisor};
        q_nxt = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = sh;
        q_nxt = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done = done_r;
  assign quotient = q_r;
endmodule
